// File: hw/rtl/pgm_ascii_stream_parser_assert.svh
// assertion helpers shared by the parser modules
// each module that uses them has clk_i and rst_ni in scope
`ifndef PGM_ASCII_STREAM_PARSER_ASSERT_SVH
`define PGM_ASCII_STREAM_PARSER_ASSERT_SVH

// same-cycle implication
`define PGMP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PGMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pgmp_pkg.sv
package pgmp_pkg;

  localparam int unsigned MaxDim        = 4096;
  localparam int unsigned MaxTokenChars = 99;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned ValueW    = 16;
  localparam int unsigned IdxW      = 12;
  localparam int unsigned DimW      = $clog2(MaxDim + 1);
  localparam int unsigned DigitCntW = $clog2(MaxTokenChars + 1);
  localparam int unsigned NumW      = 17;
  localparam int unsigned AccW      = NumW + 4;

  localparam logic [NumW-1:0]  ValueCap = 17'd65536;
  localparam logic [NumW-1:0]  ValueMax = 17'd65535;

  localparam logic [ByteW-1:0] CharNewline = 8'd10;
  localparam logic [ByteW-1:0] CharSpace   = 8'd32;
  localparam logic [ByteW-1:0] CharHash    = 8'h23;
  localparam logic [ByteW-1:0] CharUpperP  = 8'h50;
  localparam logic [ByteW-1:0] CharLowerP  = 8'h70;
  localparam logic [ByteW-1:0] CharZero    = 8'd48;
  localparam logic [ByteW-1:0] CharTwo     = 8'd50;
  localparam logic [ByteW-1:0] CharNine    = 8'd57;

  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

  typedef enum logic [2:0] {
    KIND_WIDTH   = 3'd0,
    KIND_HEIGHT  = 3'd1,
    KIND_MAXGRAY = 3'd2,
    KIND_PIXEL   = 3'd3,
    KIND_ACCEPT  = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_MAGIC      = 4'd1,
    ERR_NOT_P2     = 4'd2,
    ERR_NUMBER     = 4'd3,
    ERR_ZERO_W     = 4'd4,
    ERR_ZERO_H     = 4'd5,
    ERR_TOO_LARGE  = 4'd6,
    ERR_OVER_MAX   = 4'd7,
    ERR_EXTRA      = 4'd8,
    ERR_SHORT      = 4'd9
  } err_e;

  typedef enum logic [7:0] {
    MODE_MAGIC_P = 8'b0000_0001,
    MODE_MAGIC_2 = 8'b0000_0010,
    MODE_WIDTH   = 8'b0000_0100,
    MODE_HEIGHT  = 8'b0000_1000,
    MODE_MAXG    = 8'b0001_0000,
    MODE_PIXELS  = 8'b0010_0000,
    MODE_DONE    = 8'b0100_0000,
    MODE_COMMENT = 8'b1000_0000
  } mode_e;

  typedef struct packed {
    kind_e             kind;
    logic [ValueW-1:0] value;
    logic [IdxW-1:0]   row;
    logic [IdxW-1:0]   column;
    err_e              err;
    logic              last;
  } res_t;

  // up to two results per byte, r0 first
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t mk_err(err_e code);
    res_t r;
    r        = '0;
    r.kind   = KIND_ERROR;
    r.err    = code;
    return r;
  endfunction

  function automatic res_t mk_val(kind_e kind, logic [ValueW-1:0] value);
    res_t r;
    r       = '0;
    r.kind  = kind;
    r.value = value;
    r.err   = ERR_NONE;
    return r;
  endfunction

endpackage

// File: hw/rtl/pgm_ascii_stream_parser.sv
// plain-text graymap (P2) parser, one byte per transfer in, one result per transfer out
// input channel: data_byte_i and end_of_input_i, qualified by in_valid_i, held off
//   by in_stall_o; a transfer happens on a rising edge with valid high and stall low
// output channel: kind, value, row, column, error code and last-of-run flag,
//   qualified by out_valid_o and held off by out_stall_i
// a byte lands in an input register, the parse logic updates its state and drops
//   zero, one or two results into a four-entry result queue once two slots are free
// a result caused by a byte goes through the input register and then the queue before it can be taken
// throughput: one byte per cycle; the input stalls only while fewer than two
//   queue slots are free, i.e. when the receiver has stalled for a while
// two results from one byte only happen on the end-of-file byte, after which the
//   parser goes quiet, so the queue never falls behind a non-stalling receiver
// bytes keep being accepted and are silently dropped after an error or the
//   final verdict, until reset
// reset (rst_ni low, asynchronous) empties the queue, drops any held byte and
//   returns the parser to waiting for the magic letter
module pgm_ascii_stream_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pgmp_pkg::ByteW-1:0]  data_byte_i,
  input  logic                        end_of_input_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  kind_o,
  output logic [pgmp_pkg::ValueW-1:0] value_o,
  output logic [pgmp_pkg::IdxW-1:0]   row_o,
  output logic [pgmp_pkg::IdxW-1:0]   column_o,
  output logic [3:0]                  error_code_o,
  output logic                        last_of_run_o
);

  // parse results from one byte, handed to the queue in a single cycle
  pgmp_pkg::push_t push;
  // queue has space for a full pair
  logic            room;
  // oldest waiting result
  pgmp_pkg::res_t  head;

  pgmp_parse_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .room_i         (room),
    .push_o         (push)
  );

  pgmp_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  // unpack the head entry onto the result ports
  assign kind_o        = head.kind;
  assign value_o       = head.value;
  assign row_o         = head.row;
  assign column_o      = head.column;
  assign error_code_o  = head.err;
  assign last_of_run_o = head.last;

`include "pgm_ascii_stream_parser_assert.svh"

  // a waiting error never carries a pixel position or value
  `PGMP_ASSERT_NOW(a_err_clean, out_valid_o && kind_o == pgmp_pkg::KIND_ERROR,
                   value_o == '0 && row_o == '0 && column_o == '0,
                   "error result with payload")
  // only errors carry an error code
  `PGMP_ASSERT_NOW(a_code_only_err, out_valid_o && kind_o != pgmp_pkg::KIND_ERROR,
                   error_code_o == pgmp_pkg::ERR_NONE, "error code on a good result")
  // the input side can only be held off while results are waiting
  `PGMP_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o, "input stalled with empty queue")

endmodule

// File: hw/rtl/pgmp_parse_core.sv
module pgmp_parse_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [pgmp_pkg::ByteW-1:0] data_byte_i,
  input  logic                     end_of_input_i,
  input  logic                     room_i,
  output pgmp_pkg::push_t          push_o
);

  logic                            in_vld_q, in_vld_d;
  logic [pgmp_pkg::ByteW-1:0]      byte_q;
  logic                            eoi_q;
  logic                            accept, fire;

  pgmp_pkg::mode_e                 mode_q, mode_d, mbc_q, mbc_d, vmode;
  logic                            in_num_q, in_num_d;
  logic [pgmp_pkg::NumW-1:0]       num_q, num_d;
  logic [pgmp_pkg::DigitCntW-1:0]  dcnt_q, dcnt_d;
  logic [pgmp_pkg::DimW-1:0]       width_q, width_d, height_q, height_d;
  logic [pgmp_pkg::DimW-1:0]       row_q, row_d, col_q, col_d;
  logic [pgmp_pkg::ValueW-1:0]     maxg_q, maxg_d;
  logic                            stopped_q, stopped_d;

  logic                            is_digit;
  logic [pgmp_pkg::NumW-1:0]       digit_val;
  logic [pgmp_pkg::AccW-1:0]       acc;
  logic [pgmp_pkg::NumW-1:0]       acc_sat;
  logic [pgmp_pkg::DimW:0]         col_next, row_next;

  logic                            fin_req;
  logic [pgmp_pkg::NumW-1:0]       fin_val;
  logic                            main_vld, ver_vld;
  pgmp_pkg::res_t                  main_res, ver_res;

  assign fire       = in_vld_q && room_i;
  assign in_stall_o = in_vld_q && !room_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  assign is_digit  = (byte_q >= pgmp_pkg::CharZero) && (byte_q <= pgmp_pkg::CharNine);
  assign digit_val = pgmp_pkg::NumW'(byte_q - pgmp_pkg::CharZero);
  // value * 10 + digit, saturated just above the 16 bit range
  assign acc       = pgmp_pkg::AccW'({num_q, 3'b000}) + pgmp_pkg::AccW'({num_q, 1'b0})
                     + pgmp_pkg::AccW'(digit_val);
  assign acc_sat   = (acc > pgmp_pkg::AccW'(pgmp_pkg::ValueCap)) ?
                     pgmp_pkg::ValueCap : acc[pgmp_pkg::NumW-1:0];
  assign col_next  = {1'b0, col_q} + 1'b1;
  assign row_next  = {1'b0, row_q} + 1'b1;

  always_comb begin
    mode_d    = mode_q;
    mbc_d     = mbc_q;
    in_num_d  = in_num_q;
    num_d     = num_q;
    dcnt_d    = dcnt_q;
    width_d   = width_q;
    height_d  = height_q;
    maxg_d    = maxg_q;
    row_d     = row_q;
    col_d     = col_q;
    stopped_d = stopped_q;
    fin_req   = 1'b0;
    fin_val   = '0;
    main_vld  = 1'b0;
    main_res  = '0;
    ver_vld   = 1'b0;
    ver_res   = '0;
    vmode     = mode_q;

    if (fire && !stopped_q) begin
      if (in_num_q) begin
        if (is_digit) begin
          if (dcnt_q >= pgmp_pkg::DigitCntW'(pgmp_pkg::MaxTokenChars)) begin
            main_vld  = 1'b1;
            main_res  = pgmp_pkg::mk_err(pgmp_pkg::ERR_NUMBER);
            stopped_d = 1'b1;
          end else begin
            dcnt_d = dcnt_q + 1'b1;
            num_d  = acc_sat;
            if (eoi_q) begin
              fin_req = 1'b1;
              fin_val = acc_sat;
            end
          end
        end else begin
          // terminating byte is swallowed with the number
          fin_req = 1'b1;
          fin_val = num_q;
        end
      end else if (mode_q == pgmp_pkg::MODE_COMMENT) begin
        if (byte_q == pgmp_pkg::CharNewline) begin
          mode_d = mbc_q;
        end
      end else if (byte_q > pgmp_pkg::CharSpace) begin
        if (byte_q == pgmp_pkg::CharHash) begin
          mbc_d  = mode_q;
          mode_d = pgmp_pkg::MODE_COMMENT;
        end else begin
          case (mode_q)
            pgmp_pkg::MODE_MAGIC_P: begin
              if (byte_q == pgmp_pkg::CharUpperP || byte_q == pgmp_pkg::CharLowerP) begin
                mode_d = pgmp_pkg::MODE_MAGIC_2;
              end else begin
                main_vld  = 1'b1;
                main_res  = pgmp_pkg::mk_err(pgmp_pkg::ERR_MAGIC);
                stopped_d = 1'b1;
              end
            end
            pgmp_pkg::MODE_MAGIC_2: begin
              if (byte_q == pgmp_pkg::CharTwo) begin
                mode_d = pgmp_pkg::MODE_WIDTH;
              end else begin
                main_vld  = 1'b1;
                main_res  = pgmp_pkg::mk_err(pgmp_pkg::ERR_NOT_P2);
                stopped_d = 1'b1;
              end
            end
            pgmp_pkg::MODE_WIDTH, pgmp_pkg::MODE_HEIGHT,
            pgmp_pkg::MODE_MAXG, pgmp_pkg::MODE_PIXELS: begin
              if (is_digit) begin
                in_num_d = 1'b1;
                num_d    = digit_val;
                dcnt_d   = pgmp_pkg::DigitCntW'(1);
                // a one-digit number on the last byte completes right away
                if (eoi_q) begin
                  fin_req = 1'b1;
                  fin_val = digit_val;
                end
              end else begin
                main_vld  = 1'b1;
                main_res  = pgmp_pkg::mk_err(pgmp_pkg::ERR_NUMBER);
                stopped_d = 1'b1;
              end
            end
            default: begin
              main_vld  = 1'b1;
              main_res  = pgmp_pkg::mk_err(pgmp_pkg::ERR_EXTRA);
              stopped_d = 1'b1;
            end
          endcase
        end
      end

      // number completion, at most once per byte
      if (fin_req) begin
        in_num_d = 1'b0;
        num_d    = '0;
        dcnt_d   = '0;
        main_vld = 1'b1;
        if (fin_val > pgmp_pkg::ValueMax) begin
          main_res  = pgmp_pkg::mk_err(pgmp_pkg::ERR_TOO_LARGE);
          stopped_d = 1'b1;
        end else begin
          case (mode_q)
            pgmp_pkg::MODE_WIDTH: begin
              if (fin_val == '0) begin
                main_res  = pgmp_pkg::mk_err(pgmp_pkg::ERR_ZERO_W);
                stopped_d = 1'b1;
              end else if (fin_val > pgmp_pkg::NumW'(pgmp_pkg::MaxDim)) begin
                main_res  = pgmp_pkg::mk_err(pgmp_pkg::ERR_TOO_LARGE);
                stopped_d = 1'b1;
              end else begin
                width_d  = pgmp_pkg::DimW'(fin_val);
                main_res = pgmp_pkg::mk_val(pgmp_pkg::KIND_WIDTH, fin_val[pgmp_pkg::ValueW-1:0]);
                mode_d   = pgmp_pkg::MODE_HEIGHT;
              end
            end
            pgmp_pkg::MODE_HEIGHT: begin
              if (fin_val == '0) begin
                main_res  = pgmp_pkg::mk_err(pgmp_pkg::ERR_ZERO_H);
                stopped_d = 1'b1;
              end else if (fin_val > pgmp_pkg::NumW'(pgmp_pkg::MaxDim)) begin
                main_res  = pgmp_pkg::mk_err(pgmp_pkg::ERR_TOO_LARGE);
                stopped_d = 1'b1;
              end else begin
                height_d = pgmp_pkg::DimW'(fin_val);
                main_res = pgmp_pkg::mk_val(pgmp_pkg::KIND_HEIGHT, fin_val[pgmp_pkg::ValueW-1:0]);
                mode_d   = pgmp_pkg::MODE_MAXG;
              end
            end
            pgmp_pkg::MODE_MAXG: begin
              maxg_d   = fin_val[pgmp_pkg::ValueW-1:0];
              main_res = pgmp_pkg::mk_val(pgmp_pkg::KIND_MAXGRAY, fin_val[pgmp_pkg::ValueW-1:0]);
              row_d    = '0;
              col_d    = '0;
              mode_d   = pgmp_pkg::MODE_PIXELS;
            end
            pgmp_pkg::MODE_PIXELS: begin
              if (fin_val > {1'b0, maxg_q}) begin
                main_res  = pgmp_pkg::mk_err(pgmp_pkg::ERR_OVER_MAX);
                stopped_d = 1'b1;
              end else begin
                main_res        = pgmp_pkg::mk_val(pgmp_pkg::KIND_PIXEL,
                                                   fin_val[pgmp_pkg::ValueW-1:0]);
                main_res.row    = pgmp_pkg::IdxW'(row_q);
                main_res.column = pgmp_pkg::IdxW'(col_q);
                if (col_next >= {1'b0, width_q}) begin
                  col_d = '0;
                  row_d = row_next[pgmp_pkg::DimW-1:0];
                  if (row_next >= {1'b0, height_q}) begin
                    mode_d = pgmp_pkg::MODE_DONE;
                  end
                end else begin
                  col_d = col_next[pgmp_pkg::DimW-1:0];
                end
              end
            end
            default: begin
              main_vld = 1'b0;
            end
          endcase
        end
      end

      // end of file verdict
      if (!stopped_d && eoi_q) begin
        vmode     = (mode_d == pgmp_pkg::MODE_COMMENT) ? mbc_d : mode_d;
        ver_vld   = 1'b1;
        stopped_d = 1'b1;
        if (vmode == pgmp_pkg::MODE_DONE) begin
          ver_res = pgmp_pkg::mk_val(pgmp_pkg::KIND_ACCEPT, '0);
        end else begin
          ver_res = pgmp_pkg::mk_err(pgmp_pkg::ERR_SHORT);
        end
      end
    end
  end

  always_comb begin
    push_o         = '0;
    push_o.cnt     = {1'b0, main_vld} + {1'b0, ver_vld};
    push_o.r0      = main_vld ? main_res : ver_res;
    push_o.r0.last = !(main_vld && ver_vld);
    push_o.r1      = ver_res;
    push_o.r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mode_q    <= pgmp_pkg::MODE_MAGIC_P;
      mbc_q     <= pgmp_pkg::MODE_MAGIC_P;
      in_num_q  <= 1'b0;
      num_q     <= '0;
      dcnt_q    <= '0;
      width_q   <= '0;
      height_q  <= '0;
      maxg_q    <= '0;
      row_q     <= '0;
      col_q     <= '0;
      stopped_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      mode_q    <= mode_d;
      mbc_q     <= mbc_d;
      in_num_q  <= in_num_d;
      num_q     <= num_d;
      dcnt_q    <= dcnt_d;
      width_q   <= width_d;
      height_q  <= height_d;
      maxg_q    <= maxg_d;
      row_q     <= row_d;
      col_q     <= col_d;
      stopped_q <= stopped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
      eoi_q  <= end_of_input_i;
    end
  end

`include "pgm_ascii_stream_parser_assert.svh"

  `PGMP_ASSERT_NEXT(a_stop_sticky, stopped_q, stopped_q, "parser left the stopped state")
  `PGMP_ASSERT_NOW(a_quiet_when_stopped, stopped_q, push_o.cnt == 2'd0, "result after stop")
  `PGMP_ASSERT_NOW(a_pair_ends_run, push_o.cnt == 2'd2,
                   push_o.r1.kind == pgmp_pkg::KIND_ACCEPT || push_o.r1.kind == pgmp_pkg::KIND_ERROR,
                   "second result is not a verdict")
  `PGMP_ASSERT_NOW(a_push_has_room, push_o.cnt != 2'd0, fire, "push without room")

endmodule

// File: hw/rtl/pgmp_res_fifo.sv
module pgmp_res_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pgmp_pkg::push_t push_i,
  output logic            room_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pgmp_pkg::res_t  head_o
);

  pgmp_pkg::res_t                mem_q [pgmp_pkg::ResDepth];
  logic [pgmp_pkg::ResPtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [pgmp_pkg::ResCntW-1:0]  cnt_q, cnt_d;
  logic                          pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  // two free slots so a byte can always land both of its results
  assign room_o      = (cnt_q <= pgmp_pkg::ResCntW'(pgmp_pkg::ResDepth - 2));
  assign head_o      = mem_q[rd_ptr_q];
  assign wr_ptr_nx   = wr_ptr_q + 1'b1;

  assign wr_ptr_d = wr_ptr_q + pgmp_pkg::ResPtrW'(push_i.cnt);
  assign rd_ptr_d = rd_ptr_q + pgmp_pkg::ResPtrW'(pop);
  assign cnt_d    = cnt_q + pgmp_pkg::ResCntW'(push_i.cnt) - pgmp_pkg::ResCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.r1;
    end
  end

`include "pgm_ascii_stream_parser_assert.svh"

  `PGMP_ASSERT_NOW(a_no_overflow, push_i.cnt != 2'd0,
                   room_o, "push into a full queue")
  `PGMP_ASSERT_NOW(a_ptr_match, 1'b1,
                   pgmp_pkg::ResPtrW'(wr_ptr_q - rd_ptr_q) == cnt_q[pgmp_pkg::ResPtrW-1:0],
                   "pointers disagree with count")
  `PGMP_ASSERT_NEXT(a_drain_last, cnt_q == pgmp_pkg::ResCntW'(1) && pop && push_i.cnt == 2'd0,
                    !out_valid_o, "queue not empty after last transfer")

endmodule
